FILE: src/bb3_pkg.sv
// shared constants and types of the 3x3 box blur stream
package bb3_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 2048;
  localparam int LS_ADDR_W = $clog2(MAX_WIDTH);

  // field widths
  localparam int PIX_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = 11;
  localparam int WCFG_W = 12;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_FIELD_W = PIX_W + ROW_W + COL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  // configuration reset values and effective limits
  localparam logic [WCFG_W-1:0] WIDTH_RST = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [WCFG_W-1:0] WIDTH_MIN = 12'd3;
  localparam logic [WCFG_W-1:0] WIDTH_MAX = WCFG_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] HEIGHT_MIN = 16'd3;

  // arithmetic: column sum of three pixels, window sum of nine
  localparam int COLSUM_W = 10;
  localparam int WINSUM_W = 12;
  // floor(s / 9) = (s * 7282) >> 16 exactly for s <= 2295
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int PROD_W = WINSUM_W + RECIP_W;
  localparam int QUOT_LSB = 16;

  // window is three column cells wide
  localparam int WIN_COLS = 3;

  // output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // position tag that rides along with a pixel
  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

  // one result item in the output queue
  typedef struct packed {
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] value;
  } out_item_t;

endpackage

FILE: src/box_blur_3x3_stream.sv
// top level of the 3x3 box blur stream
//
// Takes 8-bit grayscale pixels in raster order on the s_axis channel and
// returns floor(sum / 9) of every interior 3x3 neighborhood on m_axis,
// together with the row and column of the center pixel; tlast marks the
// last interior pixel of the image. Border pixels give no result item.
// Image width and height are set through the cfg port while the block is
// idle; any write restarts the frame at row 0, column 0.
// One pixel is taken per clock while s_axis_tready is high. The result for
// pixel (y,x) leaves once pixel (y+1,x+1) has passed line store read, column
// cells, reciprocal multiply and queue. Two 2048 x 8 line stores hold the
// previous two rows; a row of three column cells holds the window.
// The output queue holds 8 items; s_axis_tready is high while fewer than
// 8 results are queued or on their way, so a stalled receiver stops the
// input only once that limit is reached, and nothing is lost.
// Reset sets width 640, height 480 and clears positions and window; the
// line stores need no clearing, since a row is only read after it is written.
module box_blur_3x3_stream
  import bb3_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] pixel
  // result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] blurred_value, [23:8] out_row, [34:24] out_col, [39:35] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast   // frame_last
);

  // configuration registers
  logic [WCFG_W-1:0] width_q;
  logic [ROW_W-1:0]  height_q;
  logic [WCFG_W-1:0] eff_width;
  logic [ROW_W-1:0]  eff_height;
  logic [WCFG_W-1:0] last_col_w;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WCFG_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective image size
  always_comb begin
    priority if (width_q < WIDTH_MIN) begin
      eff_width = WIDTH_MIN;
    end else if (width_q > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = width_q;
    end
    eff_height = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
    last_col_w = eff_width - WCFG_W'(1);
    last_col   = last_col_w[COL_W-1:0];
    last_row   = eff_height - ROW_W'(1);
  end

  // input handshake and result credits
  logic                 in_accept;
  logic                 out_accept;
  logic [OUT_CNT_W-1:0] credit_q;
  logic [OUT_CNT_W-1:0] credit_d;
  tag_t                 in_tag;

  assign s_axis_tready = (credit_q < OUT_CNT_W'(OUT_DEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;

  // raster position
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (col_q == last_col) begin
        col_d = '0;
        row_d = (row_q == last_row) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // tag of the pixel being accepted
  always_comb begin
    in_tag.emit = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    in_tag.row  = row_q - ROW_W'(1);
    in_tag.col  = col_q - COL_W'(1);
    in_tag.last = (row_q == last_row) && (col_q == last_col);
  end

  // credits count results queued or in flight
  always_comb begin
    credit_d = credit_q;
    if (in_accept && in_tag.emit) begin
      credit_d = credit_d + OUT_CNT_W'(1);
    end
    if (out_accept) begin
      credit_d = credit_d - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // stage 1: line store read in flight
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  tag_t             s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q <= s_axis_tdata[PIX_W-1:0];
      s1_col_q <= col_q;
      s1_tag_q <= in_tag;
    end
  end

  // line stores: older holds row y-2, newer holds row y-1
  logic [PIX_W-1:0] top_pix;
  logic [PIX_W-1:0] mid_pix;

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_store_older (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q[LS_ADDR_W-1:0]),
    .wdata_i (mid_pix),
    .re_i    (in_accept),
    .raddr_i (col_q[LS_ADDR_W-1:0]),
    .rdata_o (top_pix)
  );

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_store_newer (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q[LS_ADDR_W-1:0]),
    .wdata_i (s1_pix_q),
    .re_i    (in_accept),
    .raddr_i (col_q[LS_ADDR_W-1:0]),
    .rdata_o (mid_pix)
  );

  // new column sum enters the chain of window cells
  logic [COLSUM_W-1:0] new_col_sum;
  logic [COLSUM_W-1:0] cell_in  [WIN_COLS];
  logic [COLSUM_W-1:0] cell_out [WIN_COLS];

  assign new_col_sum = COLSUM_W'(top_pix) + COLSUM_W'(mid_pix) + COLSUM_W'(s1_pix_q);

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = new_col_sum;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    bb3_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_valid_q),
      .sum_i   (cell_in[k]),
      .sum_o   (cell_out[k])
    );
  end

  // stage 2: window sum and reciprocal multiply
  logic                s2_valid_q;
  tag_t                s2_tag_q;
  logic [WINSUM_W-1:0] win_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_tag_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_tag_q <= s1_tag_q;
    end
  end

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < WIN_COLS; k++) begin
      win_sum = win_sum + WINSUM_W'(cell_out[k]);
    end
  end

  // stage 3: product register
  logic              s3_valid_q;
  tag_t              s3_tag_q;
  logic [PROD_W-1:0] s3_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_tag_q  <= s2_tag_q;
      s3_prod_q <= PROD_W'(win_sum) * PROD_W'(RECIP_9);
    end
  end

  // output queue
  out_item_t            q_mem_q [OUT_DEPTH];
  out_item_t            q_wr_item;
  out_item_t            q_rd_item;
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] fill_q;
  logic [OUT_CNT_W-1:0] fill_d;

  always_comb begin
    q_wr_item.last  = s3_tag_q.last;
    q_wr_item.col   = s3_tag_q.col;
    q_wr_item.row   = s3_tag_q.row;
    q_wr_item.value = s3_prod_q[QUOT_LSB +: PIX_W];
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      q_mem_q[wr_ptr_q] <= q_wr_item;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (s3_valid_q) begin
      fill_d = fill_d + OUT_CNT_W'(1);
    end
    if (out_accept) begin
      fill_d = fill_d - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (s3_valid_q) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (out_accept) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      fill_q <= fill_d;
    end
  end

  // output port
  assign q_rd_item     = q_mem_q[rd_ptr_q];
  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, q_rd_item.col, q_rd_item.row, q_rd_item.value};
  assign m_axis_tlast  = q_rd_item.last;

  // credits bound the queue
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credits exceed queue depth");

  // every queued item holds a credit
  a_fill_le_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= credit_q)
    else $error("queue holds more items than credits");

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == OUT_CNT_W'(OUT_DEPTH)) |-> !s3_valid_q || out_accept)
    else $error("write into full output queue");

  // a configuration write restarts the frame
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("position not cleared after configuration write");

  // stores are not written and read at one address in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_accept) |-> (s1_col_q != col_q))
    else $error("line store read and write collide");

endmodule

FILE: src/bb3_ram.sv
// generic simple dual port ram with registered read
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bb3_col_cell.sv
// one window column cell: holds a column sum and hands it to its neighbor
module bb3_col_cell
  import bb3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic [COLSUM_W-1:0] sum_i,
  output logic [COLSUM_W-1:0] sum_o
);

  logic [COLSUM_W-1:0] sum_q;
  logic [COLSUM_W-1:0] sum_d;

  // take the incoming column sum on every shift
  always_comb begin
    sum_d = shift_i ? sum_i : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: verif/box_blur_3x3_stream_tb.sv
// self-checking stream testbench of the 3x3 box blur with its own predictor
`timescale 1ns / 100ps

module box_blur_3x3_stream_tb;
  import bb3_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 120;

  // clock, reset and block ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // pixels waiting to be sent, blurred results waiting to arrive
  logic [PIX_W-1:0] pixel_feed[$];
  out_item_t        pending_blur[$];

  // predictor copy of registers, line stores, window and position
  logic [WCFG_W-1:0] width_reg = WIDTH_RST;
  logic [CFG_W-1:0]  height_reg = HEIGHT_RST;
  logic [PIX_W-1:0]  older_row[MAX_WIDTH];
  logic [PIX_W-1:0]  newer_row[MAX_WIDTH];
  logic [PIX_W-1:0]  win[9];
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  // run bookkeeping
  bit          calm = 1'b0;
  bit          held = 1'b0;
  int          hold_left = 0;
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet = 0;

  box_blur_3x3_stream DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // advance the window by one pixel and queue the blurred result it yields
  function void blur_pixel(input logic [PIX_W-1:0] px);
    int unsigned w, h, c, r, sum, i;
    out_item_t   item;
    w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg < 3) ? 3 : height_reg;
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    for (i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = older_row[c];
    win[5] = newer_row[c];
    win[8] = px;
    older_row[c] = newer_row[c];
    newer_row[c] = px;
    // interior pixel one row up and one column left is complete
    if (r >= 2 && c >= 2) begin
      sum = 0;
      for (i = 0; i < 9; i++) sum += win[i];
      item.value = PIX_W'(sum / 9);
      item.row   = ROW_W'(r - 1);
      item.col   = COL_W'(c - 1);
      item.last  = (r == h - 1) && (c == w - 1);
      pending_blur.push_back(item);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function void check_field(input string what, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // pixel driver fed from pixel_feed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        blur_pixel(s_axis_tdata);
        pixels_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_feed.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_feed.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : sink
    out_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_blur.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual value %0d row %0d col %0d",
                   $time, m_axis_tdata[PIX_W-1:0], m_axis_tdata[PIX_W +: ROW_W],
                   m_axis_tdata[PIX_W+ROW_W +: COL_W]);
        end else begin
          want = pending_blur.pop_front();
          check_field("blurred_value", want.value, m_axis_tdata[PIX_W-1:0]);
          check_field("out_row", want.row, m_axis_tdata[PIX_W +: ROW_W]);
          check_field("out_col", want.col, m_axis_tdata[PIX_W+ROW_W +: COL_W]);
          check_field("frame_last", want.last, m_axis_tlast);
          check_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
        end
      end
      // one long hold-off while the sender keeps offering, so the block fills up
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held && calm && m_axis_tvalid) begin
        held <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(99) >= 13;
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, pending_blur.size());
        $display("Mismatches found");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // register write; also restarts the predicted frame
  task write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = data[WCFG_W-1:0];
    end else begin
      height_reg = data;
    end
    col_pos = 0;
    row_pos = 0;
    cfg_writes++;
  endtask

  task feed_random(input int unsigned n);
    repeat (n) pixel_feed.push_back(PIX_W'($urandom_range(255)));
  endtask

  // wait until every pixel is taken and every result is back, then let the pipe drain
  // (checked between edges so the driver's latest pick is already visible)
  task settle();
    @(negedge clk_i);
    while (pixel_feed.size() != 0 || s_axis_tvalid || pending_blur.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // stimulus phases
  initial begin
    int unsigned w, h, ew, eh, n, mode, k, random_items;
    bit          first;
    for (k = 0; k < MAX_WIDTH; k++) begin
      older_row[k] = '0;
      newer_row[k] = '0;
    end
    for (k = 0; k < 9; k++) win[k] = '0;
    random_items = 0;
    first = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry of 640 x 480: two rows and a few results of the third
    feed_random(2 * 640 + 12);
    settle();

    // directed 3 x 3 images: all white, all black, floor just below white
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    repeat (9) pixel_feed.push_back(8'hFF);
    repeat (9) pixel_feed.push_back(8'h00);
    for (k = 0; k < 9; k++) pixel_feed.push_back((k == 4) ? 8'hFE : 8'hFF);
    settle();

    // random geometries, mostly small, with partial frames and single writes
    while (random_items < 150) begin
      k = $urandom_range(99);
      if (k < 10) w = $urandom_range(2);
      else if (k < 20) w = $urandom_range(64, 13);
      else w = $urandom_range(12, 3);
      k = $urandom_range(99);
      if (k < 10) h = $urandom_range(2);
      else if (k < 14) h = 65535;
      else if (k < 20) h = $urandom_range(65535, 9);
      else h = $urandom_range(8, 3);
      mode = first ? 3 : $urandom_range(3);
      first = 1'b0;
      if (mode[0]) write_reg(CFG_IMAGE_WIDTH, {4'($urandom_range(15)), 12'(w)});
      if (mode[1]) write_reg(CFG_IMAGE_HEIGHT, 16'(h));
      ew = (w < 3) ? 3 : w;
      eh = (h < 3) ? 3 : h;
      if (eh <= 8) begin
        n = ew * eh * $urandom_range(3, 1);
        if ($urandom_range(1)) n += $urandom_range(ew * eh - 1);
      end else begin
        n = ew * $urandom_range(6, 3) + $urandom_range(ew);
      end
      feed_random(n);
      random_items += n;
      settle();
    end

    // tallest height, no idling on either side, one long receiver hold-off
    calm = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, 16'd10);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    feed_random(10 * 6);
    settle();
    calm = 1'b0;

    $display("covered %0d pixels and %0d results over %0d register writes",
             pixels_sent, results_seen, cfg_writes);
    $display("reset geometry, 3x3 frames, random and saturated sizes, partial frames, long stall");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: box_blur_3x3_stream.f
src/bb3_pkg.sv
src/bb3_ram.sv
src/bb3_col_cell.sv
src/box_blur_3x3_stream.sv
verif/box_blur_3x3_stream_tb.sv
